// File: src/hbsd_pkg.sv
// Shared constants for the Huffman bit-serial decoder.
package hbsd_pkg;

  localparam int NUM_SYMBOLS = 6;
  localparam int NUM_REGS    = 6;
  localparam int NUM_NODES   = 2 * NUM_SYMBOLS - 1;
  localparam int NUM_INNER   = NUM_SYMBOLS - 1;
  localparam int ROOT_NODE   = 2 * NUM_SYMBOLS - 2;

  localparam int NODE_W   = $clog2(NUM_NODES);
  localparam int INNER_W  = (NUM_INNER > 1) ? $clog2(NUM_INNER) : 1;
  localparam int SYM_W    = 3;
  localparam int WEIGHT_W = 12;
  localparam int SUM_W    = 16;
  localparam int CFG_IDX_W = 3;

endpackage

// File: src/huffman_bit_serial_decoder.sv
// Huffman bit-serial decoder: tree builder sequencer and one-bit-per-cycle walker unless stalled.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    code_bit  (1 bit)
//   output    out        out_valid / out_stall  symbol    (3 bits)
//   config    in         cfg_we                 cfg_index (3), cfg_data (12)
//
// One code bit is taken per cycle while in_stall is low; a leaf puts its symbol in the
// output register in the cycle after the bit is taken. Whenever the walk is at the root
// and a config write has come (and after reset), the tree is rebuilt before the next bit:
// the leaves are loaded, then for each internal node i the nodes 0 to i-1 are scanned and
// a merge step follows. in_stall is high during that rebuild and while a result waits
// under out_stall.
module huffman_bit_serial_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          code_bit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hbsd_pkg::SYM_W-1:0]    symbol,
  input  logic                          cfg_we,
  input  logic [hbsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbsd_pkg::WEIGHT_W-1:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MERGE} state_t;

  localparam logic [hbsd_pkg::NODE_W-1:0] ROOT =
    hbsd_pkg::NODE_W'(hbsd_pkg::ROOT_NODE);
  localparam logic [hbsd_pkg::NODE_W-1:0] FIRST_INNER =
    hbsd_pkg::NODE_W'(hbsd_pkg::NUM_SYMBOLS);

  logic [hbsd_pkg::WEIGHT_W-1:0] weight_reg [hbsd_pkg::NUM_REGS];
  logic [hbsd_pkg::SUM_W-1:0]    node_weight [hbsd_pkg::NUM_NODES];
  logic                          node_taken [hbsd_pkg::NUM_NODES];
  logic [hbsd_pkg::NODE_W-1:0]   left_index [hbsd_pkg::NUM_INNER];
  logic [hbsd_pkg::NODE_W-1:0]   right_index [hbsd_pkg::NUM_INNER];
  logic [hbsd_pkg::NODE_W-1:0]   walk_position;

  state_t                      state;
  logic                        dirty;
  logic [hbsd_pkg::NODE_W-1:0] build_i;
  logic [hbsd_pkg::NODE_W-1:0] scan_j;
  logic                        have1, have2;
  logic [hbsd_pkg::NODE_W-1:0] s1, s2;
  logic [hbsd_pkg::SUM_W-1:0]  m1, m2;

  logic                        in_accept;
  logic [hbsd_pkg::NODE_W-1:0] walk_off, merge_off;
  logic [hbsd_pkg::INNER_W-1:0] walk_slot, merge_slot;
  logic [hbsd_pkg::NODE_W-1:0] child;
  logic                        child_leaf;
  logic [hbsd_pkg::SUM_W-1:0]  scan_w;
  logic                        scan_live;
  logic                        start_build;

  assign start_build = (state == S_IDLE) && dirty && (walk_position == ROOT);
  assign in_stall    = (state != S_IDLE) || start_build || (dirty && walk_position == ROOT)
                       || (out_valid && out_stall);
  assign in_accept   = in_valid && !in_stall;

  assign walk_off   = walk_position - FIRST_INNER;
  assign walk_slot  = walk_off[hbsd_pkg::INNER_W-1:0];
  assign merge_off  = build_i - FIRST_INNER;
  assign merge_slot = merge_off[hbsd_pkg::INNER_W-1:0];
  assign child      = code_bit ? right_index[walk_slot] : left_index[walk_slot];
  assign child_leaf = child < FIRST_INNER;

  assign scan_w    = node_weight[scan_j];
  assign scan_live = !node_taken[scan_j];

  // weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < hbsd_pkg::NUM_REGS; k++) begin
        weight_reg[k] <= hbsd_pkg::WEIGHT_W'(1);
      end
    end else if (cfg_we && cfg_index < hbsd_pkg::CFG_IDX_W'(hbsd_pkg::NUM_REGS)) begin
      weight_reg[cfg_index] <= cfg_data;
    end
  end

  // tree build sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      dirty   <= 1'b1;
      build_i <= FIRST_INNER;
      scan_j  <= '0;
      have1   <= 1'b0;
      have2   <= 1'b0;
    end else begin
      if (cfg_we) begin
        dirty <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start_build) begin
            for (int k = 0; k < hbsd_pkg::NUM_NODES; k++) begin
              node_taken[k] <= 1'b0;
              if (k < hbsd_pkg::NUM_SYMBOLS) begin
                if (k < hbsd_pkg::NUM_REGS) begin
                  node_weight[k] <= hbsd_pkg::SUM_W'(weight_reg[k]);
                end else begin
                  node_weight[k] <= '0;
                end
              end
            end
            if (!cfg_we) begin
              dirty <= 1'b0;
            end
            build_i <= FIRST_INNER;
            scan_j  <= '0;
            have1   <= 1'b0;
            have2   <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // two lightest untaken nodes, first found wins a tie
          if (scan_live) begin
            if (!have1 || scan_w < m1) begin
              s2    <= s1;
              m2    <= m1;
              have2 <= have1;
              s1    <= scan_j;
              m1    <= scan_w;
              have1 <= 1'b1;
            end else if (!have2 || scan_w < m2) begin
              s2    <= scan_j;
              m2    <= scan_w;
              have2 <= 1'b1;
            end
          end
          if (scan_j == build_i - 1'b1) begin
            state <= S_MERGE;
          end else begin
            scan_j <= scan_j + 1'b1;
          end
        end
        S_MERGE: begin
          node_weight[build_i]    <= hbsd_pkg::SUM_W'(m1 + m2);
          node_taken[s1]          <= 1'b1;
          node_taken[s2]          <= 1'b1;
          left_index[merge_slot]  <= s1;
          right_index[merge_slot] <= s2;
          if (build_i == ROOT) begin
            state <= S_IDLE;
          end else begin
            build_i <= build_i + 1'b1;
            scan_j  <= '0;
            have1   <= 1'b0;
            have2   <= 1'b0;
            state   <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // walker and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_position <= ROOT;
      out_valid     <= 1'b0;
    end else begin
      if (in_accept && child_leaf) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        if (child_leaf) begin
          walk_position <= ROOT;
          symbol        <= child[hbsd_pkg::SYM_W-1:0];
        end else begin
          walk_position <= (child <= ROOT) ? child : ROOT;
        end
      end
    end
  end

endmodule
